FILE: hdl/tolp_pkg.sv
// Package for the TCP option list parser: option codes, status codes,
// kind decode helpers and the command word passed from front to back.
// No dependencies.
`timescale 1ns / 1ps

package tolp_pkg;

    typedef enum logic [2:0] {
        OPT_NOP    = 3'd0,
        OPT_MSS    = 3'd1,
        OPT_WSCALE = 3'd2,
        OPT_SACK   = 3'd3,
        OPT_TS     = 3'd4
    } opt_code_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_LENGTH  = 2'd1,
        ST_OVERRUN    = 2'd2,
        ST_ZERO_LEN   = 2'd3
    } parse_status_t;

    localparam logic RES_RECORD  = 1'b0;
    localparam logic RES_SUMMARY = 1'b1;

    // Option kind bytes as they appear on the wire
    localparam logic [7:0] KIND_EOL    = 8'd0;
    localparam logic [7:0] KIND_NOP    = 8'd1;
    localparam logic [7:0] KIND_MSS    = 8'd2;
    localparam logic [7:0] KIND_WSCALE = 8'd3;
    localparam logic [7:0] KIND_SACK   = 8'd4;
    localparam logic [7:0] KIND_TS     = 8'd8;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    // One command describes everything a single byte produces: an optional
    // record beat and an optional summary beat, which share the snapshot.
    typedef struct packed {
        logic               rec;
        opt_code_t          code;
        logic [3:0]         position;
        logic               sum;
        parse_status_t      status;
        logic [4:0]         count;
        logic signed [8:0]  scale;
        logic               has_ts;
        logic [31:0]        tsval;
        logic [31:0]        tsecr;
    } cmd_t;

    // Correct total length of a known kind, zero for an unknown kind.
    function automatic logic [3:0] known_len(input logic [7:0] kind);
        logic [3:0] len;
        unique case (kind)
            KIND_MSS:    len = 4'd4;
            KIND_WSCALE: len = 4'd3;
            KIND_SACK:   len = 4'd2;
            KIND_TS:     len = 4'd10;
            default:     len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic opt_code_t kind_code(input logic [7:0] kind);
        opt_code_t code;
        unique case (kind)
            KIND_MSS:    code = OPT_MSS;
            KIND_WSCALE: code = OPT_WSCALE;
            KIND_SACK:   code = OPT_SACK;
            default:     code = OPT_TS;
        endcase
        return code;
    endfunction

endpackage

FILE: hdl/tolp_front.sv
// Front end of the TCP option list parser: accepts option bytes, walks the
// kind/length/data layout and issues one command per byte that has results.
// Depends on tolp_pkg.
`timescale 1ns / 1ps

module tolp_front #(
    parameter int MAX_ORDER        = 16,
    parameter int MAX_OPTION_BYTES = 40
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_option_byte,
    input  logic [5:0]        s_options_length,
    input  logic              push_ready,
    output logic              push_valid,
    output tolp_pkg::cmd_t    push_cmd
);

    localparam int CNT_W = $clog2(MAX_ORDER + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ORDER);
    localparam logic [5:0]       MAX_LEN = 6'(MAX_OPTION_BYTES);

    logic [5:0]         pos_reg,     pos_next;
    logic [7:0]         rem_reg,     rem_next;
    logic [7:0]         kind_reg,    kind_next;
    logic [7:0]         clen_reg,    clen_next;
    logic [63:0]        shift_reg,   shift_next;
    logic [CNT_W-1:0]   cnt_reg,     cnt_next;
    logic signed [8:0]  scale_reg,   scale_next;
    logic [31:0]        tsval_reg,   tsval_next;
    logic [31:0]        tsecr_reg,   tsecr_next;
    logic               ts_seen_reg, ts_seen_next;
    logic               stopped_reg, stopped_next;
    tolp_pkg::parse_status_t status_reg, status_next;
    logic               pending_reg, pending_next;

    logic               accept;
    logic [5:0]         len;
    logic               parse;
    logic               end_pkt;
    logic [7:0]         room;
    logic [3:0]         klen;
    logic               cmp_req;
    logic               rec_req;
    logic               rec_fire;
    tolp_pkg::opt_code_t rec_code;

    assign s_ready = push_ready;
    assign accept  = s_valid && s_ready;

    assign len     = (s_options_length > MAX_LEN) ? MAX_LEN : s_options_length;
    assign parse   = (len != 6'd0) && (pos_reg < len) && !stopped_reg;
    assign end_pkt = (len == 6'd0) || (({1'b0, pos_reg} + 7'd1) >= {1'b0, len});
    // Bytes left from the start of the option (one byte before this one)
    assign room    = {2'b00, len} - {2'b00, pos_reg} + 8'd1;
    assign klen    = tolp_pkg::known_len(kind_reg);

    always_comb begin
        pos_next     = pos_reg;
        rem_next     = rem_reg;
        kind_next    = kind_reg;
        clen_next    = clen_reg;
        shift_next   = shift_reg;
        cnt_next     = cnt_reg;
        scale_next   = scale_reg;
        tsval_next   = tsval_reg;
        tsecr_next   = tsecr_reg;
        ts_seen_next = ts_seen_reg;
        stopped_next = stopped_reg;
        status_next  = status_reg;
        pending_next = pending_reg;
        cmp_req      = 1'b0;
        rec_req      = 1'b0;
        rec_code     = tolp_pkg::OPT_NOP;

        if (parse) begin
            if (pending_reg) begin
                pending_next = 1'b0;
                clen_next    = s_option_byte;
                if (s_option_byte > room) begin
                    stopped_next = 1'b1;
                    status_next  = tolp_pkg::ST_OVERRUN;
                    rem_next     = 8'd0;
                end else if (klen != 4'd0) begin
                    // A known kind is always skipped by its correct length
                    rem_next = {4'b0000, klen} - 8'd2;
                    cmp_req  = (klen == 4'd2);
                end else if (s_option_byte == 8'd0) begin
                    stopped_next = 1'b1;
                    status_next  = tolp_pkg::ST_ZERO_LEN;
                    rem_next     = 8'd0;
                end else if (s_option_byte == 8'd1) begin
                    rem_next = 8'd0;
                    rec_req  = 1'b1;
                    rec_code = tolp_pkg::OPT_NOP;
                end else begin
                    rem_next = s_option_byte - 8'd2;
                end
            end else if (rem_reg != 8'd0) begin
                shift_next = {shift_reg[55:0], s_option_byte};
                rem_next   = rem_reg - 8'd1;
                cmp_req    = (rem_reg == 8'd1);
            end else if (s_option_byte == tolp_pkg::KIND_NOP) begin
                rec_req  = 1'b1;
                rec_code = tolp_pkg::OPT_NOP;
            end else if (s_option_byte == tolp_pkg::KIND_EOL) begin
                stopped_next = 1'b1;
                status_next  = tolp_pkg::ST_OK;
                rem_next     = 8'd0;
            end else if (end_pkt) begin
                stopped_next = 1'b1;
                status_next  = tolp_pkg::ST_NO_LENGTH;
                rem_next     = 8'd0;
            end else begin
                kind_next    = s_option_byte;
                clen_next    = 8'd0;
                shift_next   = 64'd0;
                pending_next = 1'b1;
            end
        end

        // An option is only taken when its reported length was right
        if (cmp_req && (klen != 4'd0) && (clen_next == {4'b0000, klen})) begin
            if (kind_reg == tolp_pkg::KIND_WSCALE) begin
                scale_next = $signed({1'b0, shift_next[7:0]});
            end
            if (kind_reg == tolp_pkg::KIND_TS) begin
                tsval_next   = shift_next[63:32];
                tsecr_next   = shift_next[31:0];
                ts_seen_next = 1'b1;
            end
            rec_req  = 1'b1;
            rec_code = tolp_pkg::kind_code(kind_reg);
        end

        rec_fire = rec_req && (cnt_reg < MAX_CNT);
        if (rec_fire) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end

        push_cmd.rec      = rec_fire;
        push_cmd.code     = rec_code;
        push_cmd.position = 4'(cnt_reg);
        push_cmd.sum      = end_pkt;
        push_cmd.status   = status_next;
        push_cmd.count    = 5'(cnt_next);
        push_cmd.scale    = scale_next;
        push_cmd.has_ts   = ts_seen_next;
        push_cmd.tsval    = tsval_next;
        push_cmd.tsecr    = tsecr_next;

        if (end_pkt) begin
            pos_next     = 6'd0;
            rem_next     = 8'd0;
            kind_next    = 8'd0;
            clen_next    = 8'd0;
            shift_next   = 64'd0;
            cnt_next     = '0;
            stopped_next = 1'b0;
            status_next  = tolp_pkg::ST_OK;
            pending_next = 1'b0;
        end else begin
            pos_next = pos_reg + 6'd1;
        end
    end

    assign push_valid = accept && (rec_fire || end_pkt);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= 6'd0;
            rem_reg     <= 8'd0;
            kind_reg    <= 8'd0;
            clen_reg    <= 8'd0;
            shift_reg   <= 64'd0;
            cnt_reg     <= '0;
            scale_reg   <= -9'sd1;
            tsval_reg   <= 32'd0;
            tsecr_reg   <= 32'd0;
            ts_seen_reg <= 1'b0;
            stopped_reg <= 1'b0;
            status_reg  <= tolp_pkg::ST_OK;
            pending_reg <= 1'b0;
        end else if (accept) begin
            pos_reg     <= pos_next;
            rem_reg     <= rem_next;
            kind_reg    <= kind_next;
            clen_reg    <= clen_next;
            shift_reg   <= shift_next;
            cnt_reg     <= cnt_next;
            scale_reg   <= scale_next;
            tsval_reg   <= tsval_next;
            tsecr_reg   <= tsecr_next;
            ts_seen_reg <= ts_seen_next;
            stopped_reg <= stopped_next;
            status_reg  <= status_next;
            pending_reg <= pending_next;
        end
    end

endmodule

FILE: hdl/tolp_fifo.sv
// Short command queue between the front end and the back end of the parser.
// Depends on tolp_pkg.
`timescale 1ns / 1ps

module tolp_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  tolp_pkg::cmd_t    push_cmd,
    output logic              head_valid,
    input  logic              pop,
    output tolp_pkg::cmd_t    head_cmd
);

    tolp_pkg::cmd_t mem [tolp_pkg::FIFO_DEPTH];

    logic [tolp_pkg::PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [tolp_pkg::PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [tolp_pkg::FCNT_W-1:0] count_reg,  count_next;
    logic                        do_push;
    logic                        do_pop;

    assign push_ready = (count_reg != tolp_pkg::FCNT_W'(tolp_pkg::FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + tolp_pkg::PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + tolp_pkg::PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + tolp_pkg::FCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - tolp_pkg::FCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/tolp_back.sv
// Back end of the parser: expands each queued command into its record and
// summary beats and holds them in the output register.
// Depends on tolp_pkg.
`timescale 1ns / 1ps

module tolp_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid,
    input  tolp_pkg::cmd_t       head_cmd,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_result_kind,
    output logic [2:0]           m_option_code,
    output logic [3:0]           m_option_position,
    output logic [4:0]           m_recorded_count,
    output logic signed [8:0]    m_window_scale,
    output logic                 m_has_timestamp,
    output logic [31:0]          m_ts_value,
    output logic [31:0]          m_ts_echo,
    output logic [1:0]           m_parse_status,
    output logic                 m_last_of_run
);

    logic               valid_reg,   valid_next;
    logic               phase_reg,   phase_next;
    logic               kind_reg,    kind_next;
    logic [2:0]         code_reg,    code_next;
    logic [3:0]         position_reg, position_next;
    logic [4:0]         count_reg,   count_next;
    logic signed [8:0]  scale_reg,   scale_next;
    logic               has_ts_reg,  has_ts_next;
    logic [31:0]        tsval_reg,   tsval_next;
    logic [31:0]        tsecr_reg,   tsecr_next;
    logic [1:0]         status_reg,  status_next;
    logic               last_reg,    last_next;
    logic               load;

    assign load = !valid_reg || m_ready;

    always_comb begin
        valid_next    = valid_reg;
        phase_next    = phase_reg;
        kind_next     = kind_reg;
        code_next     = code_reg;
        position_next = position_reg;
        count_next    = count_reg;
        scale_next    = scale_reg;
        has_ts_next   = has_ts_reg;
        tsval_next    = tsval_reg;
        tsecr_next    = tsecr_reg;
        status_next   = status_reg;
        last_next     = last_reg;
        pop           = 1'b0;

        if (load) begin
            valid_next = head_valid;
            if (head_valid) begin
                count_next  = head_cmd.count;
                scale_next  = head_cmd.scale;
                has_ts_next = head_cmd.has_ts;
                tsval_next  = head_cmd.tsval;
                tsecr_next  = head_cmd.tsecr;
                if (head_cmd.rec && !phase_reg) begin
                    // Record beat first; the summary of the same byte follows
                    kind_next     = tolp_pkg::RES_RECORD;
                    code_next     = head_cmd.code;
                    position_next = head_cmd.position;
                    status_next   = tolp_pkg::ST_OK;
                    last_next     = !head_cmd.sum;
                    phase_next    = head_cmd.sum;
                    pop           = !head_cmd.sum;
                end else begin
                    kind_next     = tolp_pkg::RES_SUMMARY;
                    code_next     = tolp_pkg::OPT_NOP;
                    position_next = 4'd0;
                    status_next   = head_cmd.status;
                    last_next     = 1'b1;
                    phase_next    = 1'b0;
                    pop           = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        code_reg     <= code_next;
        position_reg <= position_next;
        count_reg    <= count_next;
        scale_reg    <= scale_next;
        has_ts_reg   <= has_ts_next;
        tsval_reg    <= tsval_next;
        tsecr_reg    <= tsecr_next;
        status_reg   <= status_next;
        last_reg     <= last_next;
    end

    assign m_valid           = valid_reg;
    assign m_result_kind     = kind_reg;
    assign m_option_code     = code_reg;
    assign m_option_position = position_reg;
    assign m_recorded_count  = count_reg;
    assign m_window_scale    = scale_reg;
    assign m_has_timestamp   = has_ts_reg;
    assign m_ts_value        = tsval_reg;
    assign m_ts_echo         = tsecr_reg;
    assign m_parse_status    = status_reg;
    assign m_last_of_run     = last_reg;

endmodule

FILE: hdl/tcp_option_list_parser.sv
// Top level of the TCP option list parser: front end, command queue and
// back end. Depends on tolp_pkg, tolp_front, tolp_fifo and tolp_back.
//
//   Channel   Direction  Beat carries
//   s_        in         one option byte and the packet's option length
//   m_        out        one recorded option or one end-of-packet summary
//
// One option byte is accepted every cycle while the queue has room. A byte
// produces no beat, one beat, or two beats (a record followed by the
// summary) on the last byte of a packet; the back end sends one beat per
// cycle while m_ready is high and a four-entry queue takes up the
// difference. Reset is synchronous and active low and leaves no clearing
// pass to run. Input stalls only when the queue is full: after m_ready has
// been low, or when bytes that each produce two beats arrive back to back.
`timescale 1ns / 1ps

module tcp_option_list_parser #(
    parameter int MAX_ORDER        = 16,
    parameter int MAX_OPTION_BYTES = 40
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_option_byte,
    input  logic [5:0]           s_options_length,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_result_kind,
    output logic [2:0]           m_option_code,
    output logic [3:0]           m_option_position,
    output logic [4:0]           m_recorded_count,
    output logic signed [8:0]    m_window_scale,
    output logic                 m_has_timestamp,
    output logic [31:0]          m_ts_value,
    output logic [31:0]          m_ts_echo,
    output logic [1:0]           m_parse_status,
    output logic                 m_last_of_run
);

    logic            push_valid;
    logic            push_ready;
    tolp_pkg::cmd_t  push_cmd;
    logic            head_valid;
    logic            pop;
    tolp_pkg::cmd_t  head_cmd;

    tolp_front #(
        .MAX_ORDER        (MAX_ORDER),
        .MAX_OPTION_BYTES (MAX_OPTION_BYTES)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_option_byte    (s_option_byte),
        .s_options_length (s_options_length),
        .push_ready       (push_ready),
        .push_valid       (push_valid),
        .push_cmd         (push_cmd)
    );

    tolp_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .head_valid (head_valid),
        .pop        (pop),
        .head_cmd   (head_cmd)
    );

    tolp_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .head_valid        (head_valid),
        .head_cmd          (head_cmd),
        .pop               (pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_kind     (m_result_kind),
        .m_option_code     (m_option_code),
        .m_option_position (m_option_position),
        .m_recorded_count  (m_recorded_count),
        .m_window_scale    (m_window_scale),
        .m_has_timestamp   (m_has_timestamp),
        .m_ts_value        (m_ts_value),
        .m_ts_echo         (m_ts_echo),
        .m_parse_status    (m_parse_status),
        .m_last_of_run     (m_last_of_run)
    );

endmodule
